### sv/sbdd_pkg.sv
// shared types, constants and sequencer codes for the scan beam density decimator
`timescale 1ns / 1ps

package sbdd_pkg;

	// block configuration
	localparam int MAX_BEAMS    = 4096;
	localparam int RANGE_WIDTH  = 16;
	localparam int COUNT_HW_MAX = 8191;

	// field widths
	localparam int RANGE_W = 16;
	localparam int TRIG_W  = 16;
	localparam int COUNT_W = 13;
	localparam int SPACE_W = 16;

	// datapath widths
	localparam int COORD_W = 18;
	localparam int OP_W    = COORD_W + 1;
	localparam int PROD_W  = 2 * OP_W;
	localparam int ACC_W   = 36;
	localparam int FRAC    = 15;

	// rounding offset for the q1.15 product, half a millimetre
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC - 1);

	// usable range bits and the suppression marker
	localparam logic [RANGE_W-1:0] RANGE_MASK =
		RANGE_W'((64'd1 << RANGE_WIDTH) - 64'd1);
	localparam logic [RANGE_W-1:0] RANGE_MARK = RANGE_MASK;

	// kept count saturation point
	localparam int COUNT_LIMIT_I = (MAX_BEAMS > COUNT_HW_MAX) ? COUNT_HW_MAX : MAX_BEAMS;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_LIMIT_I);

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_S,
		ST_DECIDE
	} state_t;

	// multiplier operand selection
	typedef enum logic [2:0] {
		OPS_X,
		OPS_Y,
		OPS_DX,
		OPS_DY,
		OPS_S
	} op_sel_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic    ready;
		op_sel_t sel;
		logic    cap_x;
		logic    cap_y;
		logic    acc_init;
		logic    acc_add;
		logic    decide;
	} ctrl_t;

endpackage

### sv/sbdd_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module sbdd_mul (
	input  logic                                clk,
	input  logic signed [sbdd_pkg::OP_W-1:0]    a_in,
	input  logic signed [sbdd_pkg::OP_W-1:0]    b_in,
	output logic signed [sbdd_pkg::PROD_W-1:0]  prod_q
);

	// one product per cycle, result available next cycle
	always_ff @(posedge clk) begin
		prod_q <= a_in * b_in;
	end

endmodule

### sv/sbdd_seq.sv
// sequencer stepping one beam through the shared multiplier
`timescale 1ns / 1ps

module sbdd_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_free,
	output sbdd_pkg::ctrl_t ctrl
);

	sbdd_pkg::state_t state_q;
	sbdd_pkg::state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbdd_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			sbdd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = sbdd_pkg::ST_MUL_X;
				end
			end
			sbdd_pkg::ST_MUL_X:  state_next = sbdd_pkg::ST_MUL_Y;
			sbdd_pkg::ST_MUL_Y:  state_next = sbdd_pkg::ST_SQ_X;
			sbdd_pkg::ST_SQ_X:   state_next = sbdd_pkg::ST_SQ_Y;
			sbdd_pkg::ST_SQ_Y:   state_next = sbdd_pkg::ST_SQ_S;
			sbdd_pkg::ST_SQ_S:   state_next = sbdd_pkg::ST_DECIDE;
			sbdd_pkg::ST_DECIDE: begin
				if (out_free) begin
					state_next = sbdd_pkg::ST_IDLE;
				end
			end
			default: state_next = sbdd_pkg::ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		ctrl          = '0;
		ctrl.sel      = sbdd_pkg::OPS_S;
		case (state_q)
			sbdd_pkg::ST_IDLE: begin
				ctrl.ready = 1'b1;
				ctrl.sel   = sbdd_pkg::OPS_X;
			end
			sbdd_pkg::ST_MUL_X: begin
				ctrl.sel = sbdd_pkg::OPS_X;
			end
			sbdd_pkg::ST_MUL_Y: begin
				ctrl.sel   = sbdd_pkg::OPS_Y;
				ctrl.cap_x = 1'b1;
			end
			sbdd_pkg::ST_SQ_X: begin
				ctrl.sel   = sbdd_pkg::OPS_DX;
				ctrl.cap_y = 1'b1;
			end
			sbdd_pkg::ST_SQ_Y: begin
				ctrl.sel      = sbdd_pkg::OPS_DY;
				ctrl.acc_init = 1'b1;
			end
			sbdd_pkg::ST_SQ_S: begin
				ctrl.sel     = sbdd_pkg::OPS_S;
				ctrl.acc_add = 1'b1;
			end
			sbdd_pkg::ST_DECIDE: begin
				ctrl.sel    = sbdd_pkg::OPS_S;
				ctrl.decide = out_free;
			end
			default: begin
				ctrl.sel = sbdd_pkg::OPS_S;
			end
		endcase
	end

endmodule

### sv/scan_beam_density_decimator.sv
// top level of the scan beam density decimator
`timescale 1ns / 1ps

// Each input word is one laser beam (range, cosine, sine, first-of-scan flag) and gives
// exactly one output word: the range if the beam is kept, an all-ones marker if it lies
// closer than min_spacing to the last kept point, plus a kept flag and the kept count of
// the scan. Between acceptance and the next accept, a word passes an accept state, five
// passes through the single shared 19x19 multiplier (x, y, dx squared, dy squared,
// spacing squared) and a compare state. The result sits in an output register, so a
// stalled output holds the sequencer in its compare state only when the next result is
// ready before the previous one has been taken. min_spacing must be written through
// cfg_we/cfg_wdata only while the block is idle; the block itself does not enforce this.
module scan_beam_density_decimator (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,   // min_spacing
	// beam input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,     // range_mm [15:0], beam_cos [31:16], beam_sin [47:32]
	input  logic [0:0]  s_tuser,     // first_of_scan [0]
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // range_out [15:0], kept_count [28:16], zero [31:29]
	output logic [0:0]  m_tuser      // kept [0]
);

	localparam int OP_W    = sbdd_pkg::OP_W;
	localparam int PROD_W  = sbdd_pkg::PROD_W;
	localparam int COORD_W = sbdd_pkg::COORD_W;
	localparam int ACC_W   = sbdd_pkg::ACC_W;
	localparam int RANGE_W = sbdd_pkg::RANGE_W;
	localparam int TRIG_W  = sbdd_pkg::TRIG_W;
	localparam int COUNT_W = sbdd_pkg::COUNT_W;
	localparam int SPACE_W = sbdd_pkg::SPACE_W;

	sbdd_pkg::ctrl_t ctrl;

	logic [SPACE_W-1:0]        spacing_q;
	logic [RANGE_W-1:0]        range_q;
	logic signed [TRIG_W-1:0]  cos_q;
	logic signed [TRIG_W-1:0]  sin_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic signed [COORD_W-1:0] ref_x_q;
	logic signed [COORD_W-1:0] ref_y_q;
	logic [COUNT_W-1:0]        count_q;
	logic [ACC_W-1:0]          acc_q;

	logic                      out_valid_q;
	logic [RANGE_W-1:0]        out_range_q;
	logic                      out_kept_q;
	logic [COUNT_W-1:0]        out_count_q;

	logic                      out_free;
	logic                      in_fire;
	logic signed [OP_W-1:0]    op_a;
	logic signed [OP_W-1:0]    op_b;
	logic signed [OP_W-1:0]    dx;
	logic signed [OP_W-1:0]    dy;
	logic signed [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]         round_sum;
	logic [ACC_W-1:0]          prod_low;
	logic                      keep;
	logic [COUNT_W-1:0]        count_next;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = ctrl.ready;
	assign in_fire  = s_tvalid && ctrl.ready;

	sbdd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= '0;
		end else if (cfg_we) begin
			spacing_q <= cfg_wdata;
		end
	end

	// captured beam
	always_ff @(posedge clk) begin
		if (in_fire) begin
			range_q <= s_tdata[RANGE_W-1:0] & sbdd_pkg::RANGE_MASK;
			cos_q   <= s_tdata[RANGE_W +: TRIG_W];
			sin_q   <= s_tdata[RANGE_W + TRIG_W +: TRIG_W];
		end
	end

	// offsets from the reference point
	assign dx = OP_W'(x_q) - OP_W'(ref_x_q);
	assign dy = OP_W'(y_q) - OP_W'(ref_y_q);

	// operand selection for the shared multiplier
	always_comb begin
		case (ctrl.sel)
			sbdd_pkg::OPS_X: begin
				op_a = signed'(OP_W'(range_q));
				op_b = OP_W'(cos_q);
			end
			sbdd_pkg::OPS_Y: begin
				op_a = signed'(OP_W'(range_q));
				op_b = OP_W'(sin_q);
			end
			sbdd_pkg::OPS_DX: begin
				op_a = dx;
				op_b = dx;
			end
			sbdd_pkg::OPS_DY: begin
				op_a = dy;
				op_b = dy;
			end
			sbdd_pkg::OPS_S: begin
				op_a = signed'(OP_W'(spacing_q));
				op_b = signed'(OP_W'(spacing_q));
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	sbdd_mul u_mul (
		.clk    (clk),
		.a_in   (op_a),
		.b_in   (op_b),
		.prod_q (prod_q)
	);

	// round the q1.15 product to the nearest millimetre, halves up
	assign round_sum = unsigned'(prod_q) + sbdd_pkg::ROUND_HALF;
	assign prod_low  = prod_q[ACC_W-1:0];

	// planar point and squared distance
	always_ff @(posedge clk) begin
		if (ctrl.cap_x) begin
			x_q <= round_sum[sbdd_pkg::FRAC +: COORD_W];
		end
		if (ctrl.cap_y) begin
			y_q <= round_sum[sbdd_pkg::FRAC +: COORD_W];
		end
		if (ctrl.acc_init) begin
			acc_q <= prod_low;
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + prod_low;
		end
	end

	// spacing test, product holds the squared spacing here
	assign keep       = !(acc_q < prod_low);
	assign count_next = (count_q < sbdd_pkg::COUNT_LIMIT) ? count_q + COUNT_W'(1) : count_q;

	// reference point and kept count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q <= '0;
			ref_y_q <= '0;
			count_q <= '0;
		end else if (in_fire && s_tuser[0]) begin
			ref_x_q <= '0;
			ref_y_q <= '0;
			count_q <= '0;
		end else if (ctrl.decide && keep) begin
			ref_x_q <= x_q;
			ref_y_q <= y_q;
			count_q <= count_next;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.decide) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (ctrl.decide) begin
			out_kept_q  <= keep;
			out_range_q <= keep ? range_q : sbdd_pkg::RANGE_MARK;
			out_count_q <= keep ? count_next : count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_count_q, out_range_q};
	assign m_tuser  = out_kept_q;

endmodule
